FILE: hw/rtl/rational_arith_reduce_defines.svh
// ---------------------------------------------------------------------------
// rational_arith_reduce_defines
// assertion macros shared by the rational reduce rtl
// ---------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_REDUCE_DEFINES_SVH
`define RATIONAL_ARITH_REDUCE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RAR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rational_arith_reduce: check failed");

// next-cycle implication, checked out of reset
`define RAR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rational_arith_reduce: check failed");

`endif

FILE: hw/rtl/rar_pkg.sv
// ---------------------------------------------------------------------------
// rar_pkg
// widths, codes and controller/datapath interface types
// ---------------------------------------------------------------------------
package rar_pkg;

    // operand and intermediate widths
    localparam int OPW   = 16;
    localparam int PRODW = 2 * OPW;
    localparam int SUMW  = 2 * OPW + 1;
    localparam int NUMW  = 33;
    localparam int DENW  = 31;
    localparam int KW    = $clog2(SUMW + 1);
    localparam int CW    = $clog2(SUMW + 1);
    localparam int XW    = (SUMW + 1 > NUMW) ? SUMW + 1 : NUMW;

    // operation codes
    localparam logic [1:0] K_ADD = 2'd0;
    localparam logic [1:0] K_SUB = 2'd1;
    localparam logic [1:0] K_MUL = 2'd2;
    localparam logic [1:0] K_DIV = 2'd3;

    // product select codes for the shared multiplier
    typedef logic [1:0] t_msel;
    localparam t_msel MS_P0  = 2'd0;
    localparam t_msel MS_P1  = 2'd1;
    localparam t_msel MS_DEN = 2'd2;

    typedef struct packed {
        logic  load;
        logic  mul_en;
        t_msel mul_sel;
        logic  sum;
        logic  gcd_init;
        logic  gcd_step;
        logic  div_init;
        logic  div_step;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic trivial;
        logic gcd_done;
        logic div_last;
    } t_sts;

endpackage

FILE: hw/rtl/rar_datapath.sv
// ---------------------------------------------------------------------------
// rar_datapath
// operand registers, shared multiplier, signed add, binary gcd and two
// restoring dividers that reduce the result
// ---------------------------------------------------------------------------
module rar_datapath (
    input  logic                   i_clk,
    input  rar_pkg::t_cmd          i_cmd,
    output rar_pkg::t_sts          o_sts,
    input  logic [1:0]             i_kind,
    input  logic [63:0]            i_data,
    output logic [rar_pkg::NUMW-1:0] o_res_num,
    output logic [rar_pkg::DENW-1:0] o_res_den,
    output logic                   o_zero_den
);
    import rar_pkg::*;

    // operand registers, sign and magnitude
    logic [1:0]     r_kind;
    logic           r_an_s, r_ad_s, r_bn_s, r_bd_s;
    logic [OPW-1:0] r_an_m, r_ad_m, r_bn_m, r_bd_m;

    // products and sum
    logic             r_p0_s, r_p1_s, r_dn_s, r_num_s;
    logic [PRODW-1:0] r_p0_m, r_p1_m, r_dn_m;
    logic [SUMW-1:0]  r_num_m;

    // gcd and division state
    logic            r_force, r_dz, r_neg;
    logic [SUMW-1:0] r_gp, r_gq, r_g;
    logic [KW-1:0]   r_gk;
    logic [SUMW-1:0] r_nrem, r_nquo, r_drem, r_dquo;
    logic [CW-1:0]   r_cnt;

    // output registers
    logic [NUMW-1:0] r_res_num;
    logic [DENW-1:0] r_res_den;
    logic            r_zero_den;

    logic           mx_s, my_s;
    logic [OPW-1:0] mx_m, my_m;
    logic [PRODW-1:0] prod_m;
    logic           prod_s;
    logic [SUMW-1:0] sa, sb, sum_m;
    logic           sum_s;
    logic [SUMW-1:0] gcd_val;
    logic [SUMW:0]  n_trial, d_trial;
    logic [XW-1:0]  num_ext;

    // operand unpack: two's complement to sign and magnitude
    function automatic logic [OPW:0] to_sm(input logic [OPW-1:0] v);
        logic [OPW-1:0] m;
        m = v[OPW-1] ? (~v + 1'b1) : v;
        return {v[OPW-1], m};
    endfunction

    // multiplier operand select
    always_comb begin
        mx_s = r_an_s;
        mx_m = r_an_m;
        my_s = r_bd_s;
        my_m = r_bd_m;
        case (i_cmd.mul_sel)
            MS_P0: begin
                mx_s = r_an_s;
                mx_m = r_an_m;
                my_s = (r_kind == K_MUL) ? r_bn_s : r_bd_s;
                my_m = (r_kind == K_MUL) ? r_bn_m : r_bd_m;
            end
            MS_P1: begin
                mx_s = (r_kind == K_SUB) ? ~r_bn_s : r_bn_s;
                mx_m = (r_kind == K_MUL || r_kind == K_DIV) ? '0 : r_bn_m;
                my_s = r_ad_s;
                my_m = r_ad_m;
            end
            default: begin
                mx_s = r_ad_s;
                mx_m = r_ad_m;
                my_s = (r_kind == K_DIV) ? r_bn_s : r_bd_s;
                my_m = (r_kind == K_DIV) ? r_bn_m : r_bd_m;
            end
        endcase
        prod_m = PRODW'(mx_m) * PRODW'(my_m);
        prod_s = mx_s ^ my_s;
    end

    // signed magnitude add of the two cross products
    always_comb begin
        sa = SUMW'(r_p0_m);
        sb = SUMW'(r_p1_m);
        if (r_p0_s == r_p1_s) begin
            sum_m = sa + sb;
            sum_s = r_p0_s;
        end else if (sa >= sb) begin
            sum_m = sa - sb;
            sum_s = r_p0_s;
        end else begin
            sum_m = sb - sa;
            sum_s = r_p1_s;
        end
    end

    // gcd result and divider trial subtractions
    assign gcd_val = (r_gp | r_gq) << r_gk;
    assign n_trial = {r_nrem, r_nquo[SUMW-1]};
    assign d_trial = {r_drem, r_dquo[SUMW-1]};
    assign num_ext = r_neg ? (XW'(0) - XW'(r_nquo)) : XW'(r_nquo);

    // status back to the controller
    assign o_sts.trivial  = (r_num_m == '0) || (r_dn_m == '0);
    assign o_sts.gcd_done = (r_gp == '0) || (r_gq == '0);
    assign o_sts.div_last = (r_cnt == CW'(SUMW - 1));

    always_ff @(posedge i_clk) begin
        // accept an item
        if (i_cmd.load) begin
            r_kind <= i_kind;
            {r_an_s, r_an_m} <= to_sm(i_data[OPW-1:0]);
            {r_ad_s, r_ad_m} <= to_sm(i_data[16+OPW-1:16]);
            {r_bn_s, r_bn_m} <= to_sm(i_data[32+OPW-1:32]);
            {r_bd_s, r_bd_m} <= to_sm(i_data[48+OPW-1:48]);
        end

        // one product per cycle
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                MS_P0: begin
                    r_p0_m <= prod_m;
                    r_p0_s <= prod_s;
                end
                MS_P1: begin
                    r_p1_m <= prod_m;
                    r_p1_s <= prod_s;
                end
                default: begin
                    r_dn_m <= prod_m;
                    r_dn_s <= prod_s;
                end
            endcase
        end

        if (i_cmd.sum) begin
            r_num_m <= sum_m;
            r_num_s <= sum_s;
        end

        // gcd setup, also latch the special cases
        if (i_cmd.gcd_init) begin
            r_gp    <= r_num_m;
            r_gq    <= SUMW'(r_dn_m);
            r_gk    <= '0;
            r_force <= o_sts.trivial;
            r_dz    <= (r_dn_m == '0);
            r_neg   <= r_num_s ^ r_dn_s;
        end

        // binary gcd, one move per cycle
        if (i_cmd.gcd_step) begin
            if (!r_gp[0] && !r_gq[0]) begin
                r_gp <= r_gp >> 1;
                r_gq <= r_gq >> 1;
                r_gk <= r_gk + 1'b1;
            end else if (!r_gp[0]) begin
                r_gp <= r_gp >> 1;
            end else if (!r_gq[0]) begin
                r_gq <= r_gq >> 1;
            end else if (r_gp >= r_gq) begin
                r_gp <= (r_gp - r_gq) >> 1;
            end else begin
                r_gq <= (r_gq - r_gp) >> 1;
            end
        end

        // both dividers start together
        if (i_cmd.div_init) begin
            r_g    <= gcd_val;
            r_nrem <= '0;
            r_nquo <= r_num_m;
            r_drem <= '0;
            r_dquo <= SUMW'(r_dn_m);
            r_cnt  <= '0;
        end

        // restoring division, one quotient bit per cycle
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (n_trial >= {1'b0, r_g}) begin
                r_nrem <= SUMW'(n_trial - {1'b0, r_g});
                r_nquo <= {r_nquo[SUMW-2:0], 1'b1};
            end else begin
                r_nrem <= n_trial[SUMW-1:0];
                r_nquo <= {r_nquo[SUMW-2:0], 1'b0};
            end
            if (d_trial >= {1'b0, r_g}) begin
                r_drem <= SUMW'(d_trial - {1'b0, r_g});
                r_dquo <= {r_dquo[SUMW-2:0], 1'b1};
            end else begin
                r_drem <= d_trial[SUMW-1:0];
                r_dquo <= {r_dquo[SUMW-2:0], 1'b0};
            end
        end

        // result register
        if (i_cmd.out_load) begin
            if (r_force) begin
                r_res_num  <= '0;
                r_res_den  <= DENW'(1);
                r_zero_den <= r_dz;
            end else begin
                r_res_num  <= num_ext[NUMW-1:0];
                r_res_den  <= DENW'(r_dquo);
                r_zero_den <= 1'b0;
            end
        end
    end

    assign o_res_num  = r_res_num;
    assign o_res_den  = r_res_den;
    assign o_zero_den = r_zero_den;

endmodule

FILE: hw/rtl/rar_ctrl.sv
// ---------------------------------------------------------------------------
// rar_ctrl
// sequencer for load, products, sum, gcd, division and result hand-off
// ---------------------------------------------------------------------------
`include "rational_arith_reduce_defines.svh"

module rar_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rar_pkg::t_cmd o_cmd,
    input  rar_pkg::t_sts i_sts
);
    import rar_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL0  = 4'd1;
    localparam logic [3:0] S_MUL1  = 4'd2;
    localparam logic [3:0] S_MUL2  = 4'd3;
    localparam logic [3:0] S_SUM   = 4'd4;
    localparam logic [3:0] S_GINIT = 4'd5;
    localparam logic [3:0] S_GCD   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    t_cmd       cmd;
    logic [6:0] cmd_steps;

    // next state and command decode
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_MUL0;
                end
            end
            S_MUL0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_P0;
                n_state     = S_MUL1;
            end
            S_MUL1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_P1;
                n_state     = S_MUL2;
            end
            S_MUL2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_DEN;
                n_state     = S_SUM;
            end
            S_SUM: begin
                cmd.sum = 1'b1;
                n_state = S_GINIT;
            end
            S_GINIT: begin
                cmd.gcd_init = 1'b1;
                n_state      = i_sts.trivial ? S_OUT : S_GCD;
            end
            S_GCD: begin
                if (i_sts.gcd_done) begin
                    cmd.div_init = 1'b1;
                    n_state      = S_DIV;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        n_ovalid = r_ovalid;
        if (cmd.out_load) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_cmd       = cmd;

    // step commands, at most one per cycle
    assign cmd_steps = {cmd.load, cmd.sum, cmd.gcd_init, cmd.gcd_step,
                        cmd.div_init, cmd.div_step, cmd.out_load};

    // checks
    `RAR_ASSERT_NEXT(a_accept_to_mul, i_in_valid && r_state == S_IDLE, r_state == S_MUL0)
    `RAR_ASSERT_IMPL(a_valid_from_out, $rose(r_ovalid), $past(r_state) == S_OUT)
    `RAR_ASSERT_NEXT(a_div_to_out, r_state == S_DIV && i_sts.div_last, r_state == S_OUT)
    `RAR_ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0(cmd_steps))

endmodule

FILE: hw/rtl/rational_arith_reduce.sv
// after accept the block forms the three products, the sum and the gcd setup; a zero
// numerator or denominator then goes straight to the result load, otherwise the
// binary gcd moves, divider setup, one restoring division step per quotient bit
// and the result load follow. the next item is taken once the result is in the output
// register; a valid result that the receiver has not taken holds off that load.
// reset: synchronous active-low i_rst_n clears the sequencer and output valid.
// ---------------------------------------------------------------------------
// rational_arith_reduce
// add, subtract, multiply or divide two signed fractions and reduce the
// result to lowest terms with a positive denominator
// ---------------------------------------------------------------------------
module rational_arith_reduce (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // a_num, a_den, b_num, b_den
    input  logic [1:0]  s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // res_num, res_den
    output logic [0:0]  m_axis_tuser   // zero_den
);
    import rar_pkg::*;

    t_cmd            cmd;
    t_sts            sts;
    logic [NUMW-1:0] res_num;
    logic [DENW-1:0] res_den;
    logic            zero_den;

    // sequencer
    rar_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // arithmetic
    rar_datapath u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_kind     (s_axis_tuser),
        .i_data     (s_axis_tdata),
        .o_res_num  (res_num),
        .o_res_den  (res_den),
        .o_zero_den (zero_den)
    );

    assign m_axis_tdata = {res_den, res_num};
    assign m_axis_tuser = zero_den;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// checks rational_arith_reduce against an exact fraction predictor: each
// accepted item is reduced in the testbench and the expected result is queued,
// then compared field by field with the next item from the block. directed
// corner cases come first, then random bursts with a stalling receiver, one
// long receiver hold-off and one full drain.
// ---------------------------------------------------------------------------
module tb;
    import rar_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RST_CYCLES   = 6;
    localparam int N_RANDOM     = 1730;
    localparam int HOLD_AT      = 500;
    localparam int DRAIN_AT     = 1100;
    localparam int HOLD_CYCLES  = 600;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 120;
    localparam int MAX_PRINTS   = 30;

    localparam logic [15:0] V_MAX  = 16'h7FFF;
    localparam logic [15:0] V_MIN  = 16'h8000;
    localparam logic [15:0] V_ONE  = 16'h0001;
    localparam logic [15:0] V_MONE = 16'hFFFF;
    localparam logic [15:0] V_ZERO = 16'h0000;

    // one result item: reduced numerator, denominator and zero-denominator flag
    typedef struct packed {
        logic [32:0] num;
        logic [30:0] den;
        logic        zero_den;
    } frac_t;

    class fraction_board;
        frac_t pending_fracs[$];
        int    mismatches   = 0;
        int    reduced_cnt  = 0;
        int    zero_den_cnt = 0;
        int    zero_num_cnt = 0;
        int    op_cnt[4]    = '{0, 0, 0, 0};

        // exact result in lowest terms, sign carried by the numerator
        function frac_t reduced_fraction(logic [1:0] kind, logic [63:0] data);
            longint      an, ad, bn, bd, n, d, nm, dm, p, q, t;
            logic [63:0] rn;
            bit          neg;
            frac_t       r;
            an = longint'($signed(data[15:0]));
            ad = longint'($signed(data[31:16]));
            bn = longint'($signed(data[47:32]));
            bd = longint'($signed(data[63:48]));
            case (kind)
                K_ADD: begin
                    n = an * bd + bn * ad;
                    d = ad * bd;
                end
                K_SUB: begin
                    n = an * bd - bn * ad;
                    d = ad * bd;
                end
                K_MUL: begin
                    n = an * bn;
                    d = ad * bd;
                end
                default: begin
                    n = an * bd;
                    d = ad * bn;
                end
            endcase
            // zero numerator or denominator collapses to 0/1
            if (n == 0 || d == 0) begin
                r.num      = '0;
                r.den      = 31'd1;
                r.zero_den = (d == 0);
                if (d == 0) zero_den_cnt++;
                else zero_num_cnt++;
                return r;
            end
            neg = (n < 0) != (d < 0);
            nm  = (n < 0) ? -n : n;
            dm  = (d < 0) ? -d : d;
            p   = nm;
            q   = dm;
            while (q != 0) begin
                t = p % q;
                p = q;
                q = t;
            end
            if (p > 1) reduced_cnt++;
            nm = nm / p;
            dm = dm / p;
            rn = neg ? -nm : nm;
            r.num      = rn[32:0];
            r.den      = dm[30:0];
            r.zero_den = 1'b0;
            return r;
        endfunction

        function void note_item(logic [1:0] kind, logic [63:0] data);
            op_cnt[kind]++;
            pending_fracs.push_back(reduced_fraction(kind, data));
        endfunction

        task report_mismatch(string msg);
            if (mismatches < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [63:0] data, logic zd);
            frac_t want;
            if (pending_fracs.size() == 0) begin
                report_mismatch($sformatf("unexpected result num=%0d den=%0d zero_den=%0b",
                                          $signed(data[32:0]), data[63:33], zd));
                return;
            end
            want = pending_fracs.pop_front();
            if (data[32:0] !== want.num)
                report_mismatch($sformatf("res_num got %0d want %0d",
                                          $signed(data[32:0]), $signed(want.num)));
            if (data[63:33] !== want.den)
                report_mismatch($sformatf("res_den got %0d want %0d", data[63:33], want.den));
            if (zd !== want.zero_den)
                report_mismatch($sformatf("zero_den got %0b want %0b", zd, want.zero_den));
        endtask

        function int pending();
            return pending_fracs.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // a_num, a_den, b_num, b_den
    logic [1:0]  s_axis_tuser;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // res_num, res_den
    logic [0:0]  m_axis_tuser;   // zero_den

    fraction_board board = new;
    bit            hold_req = 1'b0;
    int            idle_cycles = 0;

    rational_arith_reduce uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // note accepted inputs and check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            board.note_item(s_axis_tuser, s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser[0]);
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: stall patterns that change at random intervals, plus one long hold
    initial begin
        int mode;
        int left;
        int hold;
        int phase;
        mode  = 0;
        left  = 0;
        hold  = 0;
        phase = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (hold_req) begin
                hold_req = 1'b0;
                hold     = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(8, 80);
                end
                left--;
                case (mode)
                    0:       m_axis_tready = 1'b1;
                    1:       m_axis_tready = ($urandom_range(0, 1) == 0);
                    2:       m_axis_tready = ($urandom_range(0, 3) == 0);
                    default: m_axis_tready = phase[1];
                endcase
            end
        end
    end

    // random operand: corner values, small values, powers of two or any value, so reduction happens often
    function automatic logic [15:0] rand_operand();
        int          sel;
        logic [15:0] v;
        sel = $urandom_range(0, 15);
        case (sel)
            0:       v = V_ZERO;
            1:       v = V_ONE;
            2:       v = V_MONE;
            3:       v = V_MAX;
            4:       v = V_MIN;
            5, 6, 7, 8: v = 16'($urandom_range(0, 24) - 12);
            9, 10: begin
                v = 16'(1) << $urandom_range(0, 15);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // offer one item and wait until it is taken
    task send_item(logic [1:0] kind, logic [15:0] an, logic [15:0] ad,
                   logic [15:0] bn, logic [15:0] bd);
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = {bd, bn, ad, an};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // sender drops tvalid for the gap, with noise on the data lines
    task sender_gap(int n);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = 2'($urandom);
        s_axis_tdata  = {$urandom, $urandom};
        repeat (n - 1) @(negedge i_clk);
    endtask

    // stop sending until every expected result has come back
    task wait_all_results();
        sender_gap(1);
        while (board.pending() != 0) @(negedge i_clk);
    endtask

    // main sequence
    initial begin
        int sent;
        int burst;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = K_ADD;
        s_axis_tdata  = '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: plain cases of each operation
        send_item(K_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
        send_item(K_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
        send_item(K_MUL, -16'sd3, 16'd4, 16'd8, -16'sd6);
        send_item(K_DIV, 16'd6, -16'sd4, -16'sd9, 16'd10);
        // zero denominators and zero numerators
        send_item(K_ADD, 16'd5, V_ZERO, 16'd7, 16'd3);
        send_item(K_MUL, 16'd5, 16'd3, 16'd7, V_ZERO);
        send_item(K_DIV, 16'd3, 16'd4, V_ZERO, 16'd5);
        send_item(K_MUL, V_ZERO, 16'd9, 16'd4, 16'd7);
        send_item(K_DIV, V_ZERO, V_ZERO, V_ZERO, V_ZERO);
        // negative denominators
        send_item(K_ADD, 16'd1, V_MONE, 16'd1, V_MONE);
        send_item(K_DIV, V_MONE, V_MONE, V_ONE, V_ONE);
        // extremes of the operand range with every operation
        send_item(K_ADD, V_MIN, V_MIN, V_MIN, V_MIN);
        send_item(K_SUB, V_MIN, V_ONE, V_MAX, V_MONE);
        send_item(K_MUL, V_MIN, V_ONE, V_MIN, V_ONE);
        send_item(K_DIV, V_MIN, V_ONE, V_ONE, V_MIN);
        send_item(K_ADD, V_MAX, V_MAX, V_MAX, V_MAX);
        send_item(K_SUB, V_MAX, V_MIN, V_MIN, V_MAX);
        send_item(K_MUL, V_MAX, V_MIN, V_MAX, V_MIN);
        send_item(K_DIV, V_MAX, V_MIN, V_MIN, V_MAX);
        send_item(K_ADD, V_MAX, V_MIN, V_MIN, V_MAX);
        send_item(K_SUB, V_MIN, V_MAX, V_MAX, V_ONE);
        send_item(K_DIV, V_MIN, V_MAX, V_MAX, V_MIN);
        send_item(K_MUL, V_MONE, V_MIN, V_MIN, V_MONE);
        wait_all_results();

        // random bursts with gaps, one long receiver hold and one full drain
        sent = 0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < N_RANDOM; i++) begin
                send_item(2'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                          rand_operand(), rand_operand());
                sent++;
                if (sent == HOLD_AT) hold_req = 1'b1;
                if (sent == DRAIN_AT) wait_all_results();
            end
            if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 20));
        end

        // let the last results out, then a quiet tail
        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered: add %0d, sub %0d, mul %0d, div %0d items",
                 board.op_cnt[K_ADD], board.op_cnt[K_SUB], board.op_cnt[K_MUL],
                 board.op_cnt[K_DIV]);
        $display("covered: %0d zero denominators, %0d zero numerators, %0d reduced, %0d errors",
                 board.zero_den_cnt, board.zero_num_cnt, board.reduced_cnt, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
